FILE: hw/rtl/cobsd_pkg.sv
// Shared types and constants for the COBS stream deframer.
// No dependencies; every other file refers to this package by scoped names.
package cobsd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // Hard limit on raw bytes per frame.
  localparam logic [CNT_W-1:0] MAX_BUFFER      = 13'd4096;
  localparam logic [CNT_W-1:0] MAX_FRAME_RESET = 13'd256;

  localparam logic [BYTE_W-1:0] DELIM_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] FULL_CODE  = 8'hFF;

  // Register index, taken from paddr[2]
  localparam logic REG_MAX_FRAME = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              frame_end;
    status_e           frame_status;
    logic [CNT_W-1:0]  frame_length;
  } res_t;

endpackage

FILE: hw/rtl/cobsd_if.sv
// Valid/ready channel interfaces for raw input words and decoded result words.
// Depends on cobsd_pkg for field widths.
interface cobsd_in_if;
  logic                             valid;
  logic                             ready;
  logic [cobsd_pkg::BYTE_W-1:0]     rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cobsd_out_if;
  logic                             valid;
  logic                             ready;
  logic [cobsd_pkg::BYTE_W-1:0]     out_byte;
  logic                             byte_valid;
  logic                             frame_end;
  logic [cobsd_pkg::STATUS_W-1:0]   frame_status;
  logic [cobsd_pkg::CNT_W-1:0]      frame_length;

  modport source (output valid, output out_byte, output byte_valid, output frame_end,
                  output frame_status, output frame_length, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input frame_end,
                  input frame_status, input frame_length, output ready);
endinterface

FILE: hw/rtl/cobsd_cfg.sv
// APB register block: holds max_frame_bytes and the clamped frame capacity.
// Depends on cobsd_pkg.
module cobsd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cobsd_pkg::APB_AW-1:0]     paddr,
  input  logic [cobsd_pkg::APB_DW-1:0]     pwdata,
  output logic [cobsd_pkg::APB_DW-1:0]     prdata,
  output logic                             pready,
  output logic [cobsd_pkg::CNT_W-1:0]      cap_o
);

  logic [cobsd_pkg::CNT_W-1:0] max_frame_q, max_frame_d;
  logic [cobsd_pkg::CNT_W-1:0] cap_q, cap_d;
  logic                        wr_en;
  logic                        sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[2] == cobsd_pkg::REG_MAX_FRAME);
  assign wr_en   = psel && penable && pwrite && sel_max;

  always_comb begin
    max_frame_d = max_frame_q;
    cap_d       = cap_q;
    if (wr_en) begin
      max_frame_d = pwdata[cobsd_pkg::CNT_W-1:0];
      // clamp once here so the datapath only compares
      cap_d = (pwdata[cobsd_pkg::CNT_W-1:0] > cobsd_pkg::MAX_BUFFER) ?
              cobsd_pkg::MAX_BUFFER : pwdata[cobsd_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= cobsd_pkg::MAX_FRAME_RESET;
      cap_q       <= cobsd_pkg::MAX_FRAME_RESET;
    end else begin
      max_frame_q <= max_frame_d;
      cap_q       <= cap_d;
    end
  end

  assign prdata = sel_max ?
                  {{(cobsd_pkg::APB_DW-cobsd_pkg::CNT_W){1'b0}}, max_frame_q} :
                  '0;
  assign cap_o  = cap_q;

endmodule

FILE: hw/rtl/cobsd_core.sv
// Frame state and per-word decode: group counting, zero insertion, frame status.
// Depends on cobsd_pkg (res_t, status codes, widths).
module cobsd_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [cobsd_pkg::BYTE_W-1:0]  byte_i,
  input  logic [cobsd_pkg::CNT_W-1:0]   cap_i,
  output logic                          res_valid_o,
  output cobsd_pkg::res_t               res_o
);

  logic [cobsd_pkg::BYTE_W-1:0] grp_q, grp_d;
  logic                         full_q, full_d;
  logic                         start_q, start_d;
  logic [cobsd_pkg::CNT_W-1:0]  raw_q, raw_d;
  logic [cobsd_pkg::CNT_W-1:0]  dec_q, dec_d;
  logic                         ovf_q, ovf_d;

  always_comb begin
    grp_d       = grp_q;
    full_d      = full_q;
    start_d     = start_q;
    raw_d       = raw_q;
    dec_d       = dec_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (byte_i == cobsd_pkg::DELIM_BYTE) begin
      res_valid_o = 1'b1;
      res_o.frame_end = 1'b1;
      if (ovf_q) begin
        res_o.frame_status = cobsd_pkg::ST_OVERFLOW;
      end else if (raw_q == '0) begin
        res_o.frame_status = cobsd_pkg::ST_EMPTY;
      end else if (grp_q != '0) begin
        res_o.frame_status = cobsd_pkg::ST_TRUNC;
      end else begin
        res_o.frame_status = cobsd_pkg::ST_OK;
        res_o.frame_length = dec_q;
      end
      grp_d   = '0;
      full_d  = 1'b0;
      start_d = 1'b1;
      raw_d   = '0;
      dec_d   = '0;
      ovf_d   = 1'b0;
    end else if (ovf_q || (raw_q >= cap_i)) begin
      ovf_d = 1'b1;
    end else begin
      raw_d = raw_q + 1'b1;
      if (grp_q != '0) begin
        grp_d = grp_q - 1'b1;
        dec_d = dec_q + 1'b1;
        res_valid_o      = 1'b1;
        res_o.out_byte   = byte_i;
        res_o.byte_valid = 1'b1;
      end else begin
        // code word: a zero goes out between groups unless the last code was full
        grp_d   = byte_i - 1'b1;
        full_d  = (byte_i == cobsd_pkg::FULL_CODE);
        start_d = 1'b0;
        if (!start_q && !full_q) begin
          dec_d = dec_q + 1'b1;
          res_valid_o      = 1'b1;
          res_o.byte_valid = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q   <= '0;
      full_q  <= 1'b0;
      start_q <= 1'b1;
      raw_q   <= '0;
      dec_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (adv_i) begin
      grp_q   <= grp_d;
      full_q  <= full_d;
      start_q <= start_d;
      raw_q   <= raw_d;
      dec_q   <= dec_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

FILE: hw/rtl/cobs_stream_deframer.sv
// COBS stream deframer top level: input word register, decode core, result register.
// Depends on cobsd_pkg, cobsd_if, cobsd_cfg and cobsd_core.
//
// Usage:
//   in_i  carries raw received bytes (rx_byte); a zero byte is the frame delimiter.
//   out_o carries decoded words: data bytes (byte_valid = 1) and one frame-end
//         word per delimiter with frame_status and frame_length.
//   Code words that open a frame's first group, or follow a 0xFF code, and bytes
//   past the capacity give no output word.
//   APB address 0 holds max_frame_bytes (reset 256); the capacity is clamped to 4096.
// Timing:
//   An accepted byte is held in the input register until the result register is
//   free or being drained; its output word, if any, is then loaded into the
//   result register, which drives out_o.valid.
//   One byte per cycle is sustained while out_o.ready stays high; the combinational
//   decode step and one result register set that rate.
// Reset and stall:
//   rst_ni clears the frame state, so the first byte after reset is a code byte,
//   and empties both registers. While out_o.ready is low a full result register holds;
//   the input register still takes one more byte if empty, then in_i.ready drops.
module cobs_stream_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cobsd_in_if.sink                       in_i,
  cobsd_out_if.source                    out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cobsd_pkg::APB_AW-1:0]   paddr,
  input  logic [cobsd_pkg::APB_DW-1:0]   pwdata,
  output logic [cobsd_pkg::APB_DW-1:0]   prdata,
  output logic                           pready
);

  logic                          in_valid_q, in_valid_d;
  logic [cobsd_pkg::BYTE_W-1:0]  in_byte_q;
  logic                          out_valid_q, out_valid_d;
  cobsd_pkg::res_t               out_res_q;
  logic                          adv;
  logic                          core_res_valid;
  cobsd_pkg::res_t               core_res;
  logic [cobsd_pkg::CNT_W-1:0]   cap;
  logic                          in_take;

  cobsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  cobsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .byte_i      (in_byte_q),
    .cap_i       (cap),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  // the held word moves on whenever the result slot is free or being drained
  assign adv      = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;
  assign in_take  = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv && core_res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.rx_byte;
    end
    if (adv && core_res_valid) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_res_q.out_byte;
  assign out_o.byte_valid   = out_res_q.byte_valid;
  assign out_o.frame_end    = out_res_q.frame_end;
  assign out_o.frame_status = out_res_q.frame_status;
  assign out_o.frame_length = out_res_q.frame_length;

  // input only backs up when both registers are full and the sink stalls
  a_ready_low_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_valid_q && out_valid_q && !out_o.ready)
  ) else $error("input stalled without a full pipeline");

  // a delimiter that moves on always yields a frame-end word next cycle
  a_delim_gives_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_byte_q == cobsd_pkg::DELIM_BYTE)) |=> (out_valid_q && out_res_q.frame_end)
  ) else $error("delimiter produced no frame-end word");

  // failed frames report zero length
  a_err_len_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.frame_end && (out_res_q.frame_status != cobsd_pkg::ST_OK))
      |-> (out_res_q.frame_length == '0)
  ) else $error("nonzero length on a failed frame");

endmodule
